@@ design/tlnvf_pkg.sv @@
// Package for the text line number and visible-character filter.
// Holds byte constants, configuration types and register indexes.
// No dependencies.
package tlnvf_pkg;

  localparam int NUMBER_DIGITS_DEF = 6;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_UPPER_I = 8'h49;
  localparam logic [7:0] CH_UPPER_M = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_META_LO = 8'h80;
  localparam logic [7:0] CH_META_HI = 8'h9F;
  localparam logic [7:0] CH_CTRL_HI = 8'h1F;
  localparam logic [7:0] CH_OFFSET = 8'h40;

  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUMBER_ALL       = 3'd0,
    REG_NUMBER_NONBLANK  = 3'd1,
    REG_SQUEEZE_BLANK    = 3'd2,
    REG_SHOW_ENDS        = 3'd3,
    REG_SHOW_TABS        = 3'd4,
    REG_SHOW_NONPRINTING = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  // Kind of escape prefix placed before the final character.
  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_CARET = 2'd1,
    ESC_META  = 2'd2
  } esc_kind_t;

endpackage

@@ design/tlnvf_core.sv @@
// Per-item transform: line state registers and the combinational expansion
// of one input byte into its full list of result bytes.
// Depends on tlnvf_pkg.
module tlnvf_core #(
  parameter int NUMBER_DIGITS = tlnvf_pkg::NUMBER_DIGITS_DEF,
  parameter int MAX_RES       = NUMBER_DIGITS + 5,
  parameter int CNT_W         = $clog2(MAX_RES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tlnvf_pkg::cfg_t             cfg,
  input  logic                        accept,
  input  logic [7:0]                  data_byte,
  input  logic                        new_file,
  output logic [MAX_RES-1:0][7:0]     res_bytes,
  output logic [CNT_W-1:0]            res_count
);
  import tlnvf_pkg::*;

  logic [7:0]                    previous_byte;
  logic                          blank_line_seen;
  logic [NUMBER_DIGITS-1:0][3:0] line_digits;

  logic [7:0]                    previous_byte_next;
  logic                          blank_line_seen_next;
  logic [NUMBER_DIGITS-1:0][3:0] line_digits_next;

  logic [7:0]                    eff_prev;
  logic                          eff_blank;
  logic [NUMBER_DIGITS-1:0][3:0] eff_digits;
  logic [NUMBER_DIGITS-1:0][3:0] bumped;
  logic [MAX_RES-1:0][7:0]       num_bytes;
  logic                          squeeze;
  logic                          numbering;
  logic                          dollar;
  esc_kind_t                     esc_kind;
  logic [7:0]                    final_ch;
  logic [2:0][7:0]               esc_bytes;
  logic [CNT_W-1:0]              num_len;
  logic [CNT_W-1:0]              pos_dollar;
  logic [CNT_W-1:0]              pos_esc;
  logic [CNT_W-1:0]              pos_final;
  logic [CNT_W-1:0]              esc_len;

  // A new file starts from cleared line state.
  always_comb begin
    if (new_file) begin
      eff_prev   = CH_LF;
      eff_blank  = 1'b0;
      eff_digits = '0;
    end else begin
      eff_prev   = previous_byte;
      eff_blank  = blank_line_seen;
      eff_digits = line_digits;
    end
  end

  // Decimal increment that sticks at all nines.
  always_comb begin
    logic low_nines;
    logic all_nines;
    low_nines = 1'b1;
    all_nines = 1'b1;
    bumped    = eff_digits;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (eff_digits[i] != 4'd9) all_nines = 1'b0;
    end
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (!all_nines && low_nines) begin
        bumped[i] = (eff_digits[i] == 4'd9) ? 4'd0 : eff_digits[i] + 4'd1;
      end
      low_nines = low_nines && (eff_digits[i] == 4'd9);
    end
  end

  // Number field, most significant digit first, leading zeros as spaces.
  always_comb begin
    logic seen;
    seen      = 1'b0;
    num_bytes = '0;
    for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      seen = seen || (bumped[i] != 4'd0) || (i == 0);
      num_bytes[NUMBER_DIGITS - 1 - i] = seen ? {4'h3, bumped[i]} : CH_SPACE;
    end
    num_bytes[NUMBER_DIGITS] = CH_TAB;
  end

  always_comb begin
    squeeze   = cfg.squeeze_blank && (eff_prev == CH_LF) && (data_byte == CH_LF) &&
                eff_blank;
    numbering = (eff_prev == CH_LF) &&
                ((cfg.number_all && !cfg.number_nonblank) ||
                 (cfg.number_nonblank && (data_byte != CH_LF)));
    dollar    = cfg.show_ends && (data_byte == CH_LF);
  end

  // Escape notation for tabs and nonprinting bytes.
  always_comb begin
    esc_kind = ESC_NONE;
    final_ch = data_byte;
    if (cfg.show_tabs && (data_byte == CH_TAB)) begin
      esc_kind = ESC_CARET;
      final_ch = CH_UPPER_I;
    end else if (cfg.show_nonprinting) begin
      if (data_byte >= CH_META_LO && data_byte <= CH_META_HI) begin
        esc_kind = ESC_META;
        final_ch = data_byte - CH_OFFSET;
      end else if (data_byte == CH_DEL) begin
        esc_kind = ESC_CARET;
        final_ch = CH_QMARK;
      end else if (data_byte <= CH_CTRL_HI && data_byte != CH_LF &&
                   data_byte != CH_TAB) begin
        esc_kind = ESC_CARET;
        final_ch = data_byte + CH_OFFSET;
      end
    end
  end

  always_comb begin
    case (esc_kind)
      ESC_CARET: begin
        esc_len   = CNT_W'(1);
        esc_bytes = {8'h00, 8'h00, CH_CARET};
      end
      ESC_META: begin
        esc_len   = CNT_W'(3);
        esc_bytes = {CH_CARET, CH_DASH, CH_UPPER_M};
      end
      default: begin
        esc_len   = '0;
        esc_bytes = '0;
      end
    endcase
  end

  // Each result position picks its byte from the segment it falls in.
  always_comb begin
    logic [CNT_W-1:0] p;
    logic [CNT_W-1:0] k;
    num_len    = numbering ? CNT_W'(NUMBER_DIGITS + 1) : '0;
    pos_dollar = num_len;
    pos_esc    = num_len + CNT_W'(dollar);
    pos_final  = pos_esc + esc_len;
    res_count  = squeeze ? '0 : pos_final + CNT_W'(1);
    for (int i = 0; i < MAX_RES; i++) begin
      p = CNT_W'(i);
      k = p - pos_esc;
      if (p < num_len) begin
        res_bytes[i] = num_bytes[i];
      end else if (dollar && p == pos_dollar) begin
        res_bytes[i] = CH_DOLLAR;
      end else if (p >= pos_esc && p < pos_final) begin
        res_bytes[i] = esc_bytes[k[1:0]];
      end else if (p == pos_final) begin
        res_bytes[i] = final_ch;
      end else begin
        res_bytes[i] = 8'h00;
      end
    end
  end

  always_comb begin
    if (squeeze) begin
      previous_byte_next   = CH_LF;
      blank_line_seen_next = eff_blank;
      line_digits_next     = eff_digits;
    end else begin
      previous_byte_next   = final_ch;
      blank_line_seen_next = (eff_prev == CH_LF) && (data_byte == CH_LF);
      line_digits_next     = numbering ? bumped : eff_digits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_byte   <= CH_LF;
      blank_line_seen <= 1'b0;
      line_digits     <= '0;
    end else if (accept) begin
      previous_byte   <= previous_byte_next;
      blank_line_seen <= blank_line_seen_next;
      line_digits     <= line_digits_next;
    end
  end

endmodule

@@ design/tlnvf_outbuf.sv @@
// Result register: holds the expanded bytes of one item and shifts them out
// one per output handshake. Depends on tlnvf_pkg only for the default of MAX_RES.
// No submodules.
module tlnvf_outbuf #(
  parameter int MAX_RES = tlnvf_pkg::NUMBER_DIGITS_DEF + 5,
  parameter int CNT_W   = $clog2(MAX_RES + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic [MAX_RES-1:0][7:0] load_bytes,
  input  logic [CNT_W-1:0]        load_count,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_byte,
  output logic                    last_of_run,
  output logic                    can_load
);

  logic [MAX_RES-1:0][7:0] buffer;
  logic [CNT_W-1:0]        count;
  logic                    take;

  assign out_valid   = (count != '0);
  assign out_byte    = buffer[0];
  assign last_of_run = (count == CNT_W'(1));
  assign take        = out_valid && out_ready;
  // A new item may enter as the last pending byte leaves.
  assign can_load    = !out_valid || (take && last_of_run);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= load_count;
    end else if (take) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buffer <= load_bytes;
    end else if (take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        buffer[i] <= buffer[i + 1];
      end
      buffer[MAX_RES-1] <= 8'h00;
    end
  end

endmodule

@@ design/text_line_number_visible_filter.sv @@
// The first result byte of an item is shown the cycle after it is accepted.
// One result byte per cycle while out_ready is high; an item is accepted every cycle
// while each yields one byte, and a longer item holds the input until its last byte is
// taken (set by the single result shift register). Squeezed items yield no byte.
// Reset (synchronous, active high) clears options, line state and pending results.
module text_line_number_visible_filter #(
  parameter int NUMBER_DIGITS = tlnvf_pkg::NUMBER_DIGITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [tlnvf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                              cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        data_byte,
  input  logic                              new_file,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_byte,
  output logic                              last_of_run
);
  import tlnvf_pkg::*;

  localparam int MAX_RES = NUMBER_DIGITS + 5;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  cfg_t                    cfg;
  logic                    accept;
  logic [MAX_RES-1:0][7:0] res_bytes;
  logic [CNT_W-1:0]        res_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NUMBER_ALL:       cfg.number_all       <= cfg_data;
        REG_NUMBER_NONBLANK:  cfg.number_nonblank  <= cfg_data;
        REG_SQUEEZE_BLANK:    cfg.squeeze_blank    <= cfg_data;
        REG_SHOW_ENDS:        cfg.show_ends        <= cfg_data;
        REG_SHOW_TABS:        cfg.show_tabs        <= cfg_data;
        REG_SHOW_NONPRINTING: cfg.show_nonprinting <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = in_valid && in_ready;

  tlnvf_core #(
    .NUMBER_DIGITS (NUMBER_DIGITS),
    .MAX_RES       (MAX_RES),
    .CNT_W         (CNT_W)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .data_byte (data_byte),
    .new_file  (new_file),
    .res_bytes (res_bytes),
    .res_count (res_count)
  );

  tlnvf_outbuf #(
    .MAX_RES (MAX_RES),
    .CNT_W   (CNT_W)
  ) u_outbuf (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .load_bytes  (res_bytes),
    .load_count  (res_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .can_load    (in_ready)
  );

endmodule

@@ design/tlnvf_checker.sv @@
// Port-level checks for the filter, attached to the top level by bind.
// Depends only on the top level's ports.
module tlnvf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run
);

  // A held result byte stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("output item changed while stalled");

  // The input stalls only while bytes other than a departing last one are pending.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !(out_ready && last_of_run))
    else $error("input stalled with no pending output");

  // A run does not end early: a taken byte that is not last is followed by more.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("output run ended without last marker");

  // Nothing is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("output not empty after reset");

endmodule

bind text_line_number_visible_filter tlnvf_checker u_tlnvf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .last_of_run (last_of_run)
);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for text_line_number_visible_filter.
// Predicts every shown byte from its own copy of the options and line state.
// Depends on tlnvf_pkg and the filter RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tlnvf_pkg::*;

  localparam int NUMBER_DIGITS = NUMBER_DIGITS_DEF;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam int SETTLE_CYCLES = 4;
  localparam int FINAL_WAIT_LIMIT = 20000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } shown_byte_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic                   cfg_data = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             data_byte = '0;
  logic                   new_file = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             out_byte;
  logic                   last_of_run;

  // Predictor state.
  cfg_t       opts = '0;
  logic [7:0] prev_char = CH_LF;
  bit         blank_seen = 1'b0;
  logic [3:0] line_count [NUMBER_DIGITS];

  shown_byte_t shown_expected[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_left = 0;
  int error_count = 0;
  int items_sent = 0;
  int bytes_checked = 0;
  int squeezed_count = 0;
  int settings_applied = 0;

  text_line_number_visible_filter #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .new_file   (new_file),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last_of_run(last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("text_line_number_visible_filter regression: fail");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task automatic clear_lines();
    int k;
    prev_char = CH_LF;
    blank_seen = 1'b0;
    for (k = 0; k < NUMBER_DIGITS; k++) begin
      line_count[k] = '0;
    end
  endtask

  // Decimal increment that sticks at all nines.
  task automatic bump_line_count();
    bit all_nines;
    int k;
    all_nines = 1'b1;
    for (k = 0; k < NUMBER_DIGITS; k++) begin
      if (line_count[k] != 4'd9) all_nines = 1'b0;
    end
    if (!all_nines) begin
      for (k = 0; k < NUMBER_DIGITS; k++) begin
        if (line_count[k] == 4'd9) begin
          line_count[k] = 4'd0;
        end else begin
          line_count[k] = line_count[k] + 4'd1;
          break;
        end
      end
    end
  endtask

  task automatic predict_shown_bytes(input logic [7:0] b, input logic nf);
    logic [7:0]  c;
    logic [7:0]  run[$];
    shown_byte_t entry;
    bit          lead;
    bit          numbered;
    int          k;
    c = b;
    if (nf) clear_lines();
    if (opts.squeeze_blank && prev_char == CH_LF && c == CH_LF && blank_seen) begin
      squeezed_count++;
      return;
    end
    blank_seen = (prev_char == CH_LF && c == CH_LF);
    numbered = (prev_char == CH_LF) &&
               ((opts.number_all && !opts.number_nonblank) ||
                (opts.number_nonblank && c != CH_LF));
    if (numbered) begin
      bump_line_count();
      lead = 1'b1;
      for (k = NUMBER_DIGITS - 1; k >= 0; k--) begin
        if (line_count[k] != 4'd0 || k == 0) lead = 1'b0;
        run.push_back(lead ? CH_SPACE : CH_ZERO + 8'(line_count[k]));
      end
      run.push_back(CH_TAB);
    end
    if (opts.show_ends && c == CH_LF) run.push_back(CH_DOLLAR);
    if (opts.show_tabs && c == CH_TAB) begin
      run.push_back(CH_CARET);
      c = CH_UPPER_I;
    end
    if (opts.show_nonprinting) begin
      if (c >= CH_META_LO && c <= CH_META_HI) begin
        run.push_back(CH_UPPER_M);
        run.push_back(CH_DASH);
        run.push_back(CH_CARET);
        c = c - CH_OFFSET;
      end else if (c == CH_DEL) begin
        run.push_back(CH_CARET);
        c = CH_QMARK;
      end else if (c <= CH_CTRL_HI && c != CH_LF && c != CH_TAB) begin
        run.push_back(CH_CARET);
        c = c + CH_OFFSET;
      end
    end
    run.push_back(c);
    prev_char = c;
    for (k = 0; k < run.size(); k++) begin
      entry.ch = run[k];
      entry.last = (k == run.size() - 1);
      shown_expected.push_back(entry);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready pattern and comparison
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_ready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_shown
    shown_byte_t want;
    if (!rst && out_valid && out_ready) begin
      bytes_checked++;
      if (shown_expected.size() == 0) begin
        note_mismatch($sformatf("unexpected byte 0x%02h last=%0b", out_byte, last_of_run));
      end else begin
        want = shown_expected.pop_front();
        if (out_byte !== want.ch) begin
          note_mismatch($sformatf("out_byte expected 0x%02h got 0x%02h", want.ch, out_byte));
        end
        if (last_of_run !== want.last) begin
          note_mismatch($sformatf("last_of_run expected %0b got %0b (byte 0x%02h)",
                                  want.last, last_of_run, want.ch));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [7:0] b, input logic nf);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    new_file <= nf;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_shown_bytes(b, nf);
    items_sent++;
    @(negedge clk);
  endtask

  // Stop sending and wait until every predicted byte has come out, then wait out
  // SETTLE_CYCLES as well. A squeezed newline yields no byte to wait for.
  task automatic drain();
    in_valid <= 1'b0;
    while (shown_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic option_bit(input cfg_t v, input cfg_index_t idx);
    case (idx)
      REG_NUMBER_ALL:       return v.number_all;
      REG_NUMBER_NONBLANK:  return v.number_nonblank;
      REG_SQUEEZE_BLANK:    return v.squeeze_blank;
      REG_SHOW_ENDS:        return v.show_ends;
      REG_SHOW_TABS:        return v.show_tabs;
      REG_SHOW_NONPRINTING: return v.show_nonprinting;
      default:              return 1'b0;
    endcase
  endfunction

  // Writes every option, then the two unused indexes, which must be ignored.
  task automatic apply_options(input cfg_t v);
    cfg_index_t idx;
    int         k;
    for (k = 0; k <= int'(REG_SHOW_NONPRINTING); k++) begin
      idx = cfg_index_t'(k);
      cfg_write <= 1'b1;
      cfg_index <= idx;
      cfg_data <= option_bit(v, idx);
      @(negedge clk);
    end
    cfg_index <= REG_UNUSED_LO;
    cfg_data <= 1'($urandom_range(1));
    @(negedge clk);
    cfg_index <= REG_UNUSED_HI;
    cfg_data <= 1'($urandom_range(1));
    @(negedge clk);
    cfg_write <= 1'b0;
    opts = v;
    settings_applied++;
  endtask

  function automatic logic pick_new_file();
    return ($urandom_range(39) == 0);
  endfunction

  // Printable text as the largest share, with tabs, control, DEL, meta and high bytes.
  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 8'($urandom_range(8'h7E, 8'h20));
    if (r < 50) return CH_TAB;
    if (r < 62) return 8'($urandom_range(CH_CTRL_HI, 0));
    if (r < 67) return CH_DEL;
    if (r < 80) return 8'($urandom_range(CH_META_HI, CH_META_LO));
    return 8'($urandom_range(8'hFF, 8'hA0));
  endfunction

  // Sends lines of random text, runs of blank lines and some loose bytes.
  task automatic send_random_text(input int n);
    int sent;
    int len;
    int kind;
    int k;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        len = $urandom_range(7);
        for (k = 0; k < len && sent < n; k++) begin
          send_item(pick_text_byte(), pick_new_file());
          sent++;
        end
        if (sent < n) begin
          send_item(CH_LF, pick_new_file());
          sent++;
        end
      end else if (kind < 85) begin
        len = $urandom_range(4, 2);
        for (k = 0; k < len && sent < n; k++) begin
          send_item(CH_LF, pick_new_file());
          sent++;
        end
      end else begin
        send_item(8'($urandom_range(8'hFF, 0)), pick_new_file());
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // With all options off every byte, control bytes included, passes unchanged.
  task automatic test_plain_passthrough();
    send_item(8'h00, 1'b1);
    send_item(CH_TAB, 1'b0);
    send_item(CH_DEL, 1'b0);
    send_item(CH_META_LO, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_LF, 1'b0);
  endtask

  // Every option on: the widest expansion, each escape class and squeezing.
  task automatic test_all_options();
    drain();
    apply_options('1);
    send_item(CH_META_LO, 1'b1);
    send_item(CH_TAB, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(CH_CTRL_HI, 1'b0);
    send_item(CH_DEL, 1'b0);
    send_item(CH_META_HI, 1'b0);
    send_item(8'hA0, 1'b0);
    send_item(CH_LF, 1'b0);
    send_item(CH_LF, 1'b0);
    send_item(CH_LF, 1'b0);
    send_item(CH_LF, 1'b0);
    send_item(8'h7E, 1'b0);
  endtask

  // Numbering of every line, blank ones too, and a restart on a new file.
  task automatic test_number_every_line();
    cfg_t v;
    v = '0;
    v.number_all = 1'b1;
    drain();
    apply_options(v);
    send_item(CH_LF, 1'b0);
    send_item(CH_LF, 1'b0);
    send_item(CH_SPACE, 1'b1);
    send_item(CH_LF, 1'b0);
  endtask

  task automatic test_random_text(input int send_pct, input int recv_pct);
    int chunk;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (chunk = 0; chunk < 3; chunk++) begin
      drain();
      apply_options(cfg_t'($urandom_range(63)));
      send_random_text(35);
    end
  endtask

  // The receiver stalls long enough for the block to back up into its input,
  // then the sender waits for every pending byte.
  task automatic test_backpressure();
    cfg_t v;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    v = '1;
    v.number_nonblank = 1'b0;
    drain();
    apply_options(v);
    hold_off_left = 80;
    send_random_text(30);
    drain();
  endtask

  initial begin : run_tests
    int k;
    for (k = 0; k < NUMBER_DIGITS; k++) begin
      line_count[k] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_plain_passthrough();
    test_all_options();
    test_number_every_line();
    test_random_text(18, 66);
    test_random_text(66, 18);
    test_random_text(0, 0);
    test_backpressure();

    in_valid <= 1'b0;
    for (k = 0; k < FINAL_WAIT_LIMIT && shown_expected.size() != 0; k++) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (shown_expected.size() != 0) begin
      note_mismatch($sformatf("%0d predicted bytes never came out", shown_expected.size()));
    end

    $display("Sent %0d text bytes under %0d option settings; %0d newlines squeezed.",
             items_sent, settings_applied, squeezed_count);
    $display("Checked %0d output bytes, %0d mismatches.", bytes_checked, error_count);
    if (error_count == 0) begin
      $display("text_line_number_visible_filter regression: pass");
    end else begin
      $display("text_line_number_visible_filter regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/tlnvf_pkg.sv
design/tlnvf_core.sv
design/tlnvf_outbuf.sv
design/text_line_number_visible_filter.sv
design/tlnvf_checker.sv
tb/sv/testbench.sv
